@@ hw/rtl/rle_glyph_blend_blitter_macros.svh @@
// Assertion macros used by the checker file of the glyph blitter.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef RLE_GLYPH_BLEND_BLITTER_MACROS_SVH
`define RLE_GLYPH_BLEND_BLITTER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RGBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define RGBB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rgbb_pkg.sv @@
// Package of the glyph blitter: codes, constants, controller types.
// Depends on nothing; every other RTL file of the block but the macros header uses it.
package rgbb_pkg;

  // Default geometry widths.
  localparam int COORD_BITS_DEF = 12;
  localparam int DIM_BITS_DEF   = 8;

  // Fixed widths of the item fields.
  localparam int CNT_BITS   = 8;
  localparam int CHAN_BITS  = 8;
  localparam int COLOR_BITS = 32;
  localparam int HEIGHT_BITS = 8;
  localparam int LAYER_BITS = 4;
  localparam int NUM_CHAN   = 3;

  // Narrowest supported glyph.
  localparam int MIN_WIDTH = 8;

  localparam logic [CHAN_BITS-1:0] COV_MAX      = 8'd255;
  localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CHAN_BITS-1:0] ALPHA_CLEAR  = 8'h00;

  // Request codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_RUN   = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FONT_COLOR   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BG_COLOR     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GLYPH_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAYER        = 2'd3;

  // Register reset values.
  localparam logic [COLOR_BITS-1:0]  FONT_COLOR_RST   = 32'hFFFF_FFFF;
  localparam logic [COLOR_BITS-1:0]  BG_COLOR_RST     = 32'h0000_0000;
  localparam logic [HEIGHT_BITS-1:0] GLYPH_HEIGHT_RST = 8'd16;
  localparam logic [LAYER_BITS-1:0]  LAYER_RST        = 4'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic load;
    logic mult;
    logic add;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_run;
    logic count_nz;
    logic out_free;
    logic span_last;
  } ctrl_stat_t;

endpackage

@@ hw/rtl/rgbb_if.sv @@
// Valid/ready channel interfaces of the glyph blitter: run input and span output.
// Depends on rgbb_pkg for default and field widths.
interface rgbb_in_if #(
  parameter int COORD_BITS = rgbb_pkg::COORD_BITS_DEF,
  parameter int DIM_BITS   = rgbb_pkg::DIM_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [COORD_BITS-1:0]         origin_x;
  logic [COORD_BITS-1:0]         origin_y;
  logic [DIM_BITS-1:0]           glyph_width;
  logic [rgbb_pkg::CHAN_BITS-1:0] run_value;
  logic [rgbb_pkg::CNT_BITS-1:0]  run_count;

  modport source (
    output valid, req_type, origin_x, origin_y, glyph_width, run_value, run_count,
    input  ready
  );
  modport sink (
    input  valid, req_type, origin_x, origin_y, glyph_width, run_value, run_count,
    output ready
  );
endinterface

interface rgbb_out_if #(
  parameter int COORD_BITS = rgbb_pkg::COORD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [COORD_BITS:0]             span_x;
  logic [COORD_BITS:0]             span_y;
  logic [rgbb_pkg::CNT_BITS-1:0]   span_length;
  logic [rgbb_pkg::COLOR_BITS-1:0] span_color;
  logic                            paint;
  logic [rgbb_pkg::LAYER_BITS-1:0] span_layer;
  logic                            last_of_run;
  logic                            glyph_done;
  logic                            overrun;

  modport source (
    output valid, span_x, span_y, span_length, span_color, paint, span_layer,
           last_of_run, glyph_done, overrun,
    input  ready
  );
  modport sink (
    input  valid, span_x, span_y, span_length, span_color, paint, span_layer,
           last_of_run, glyph_done, overrun,
    output ready
  );
endinterface

@@ hw/rtl/rgbb_ctrl.sv @@
// Controller of the glyph blitter: sequences accept, blend and span emission.
// Depends on rgbb_pkg for the state, command and status types.
module rgbb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rgbb_pkg::ctrl_stat_t stat_i,
  output rgbb_pkg::ctrl_cmd_t  cmd_o
);

  rgbb_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rgbb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      rgbb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!stat_i.req_run) begin
            cmd_o.start = 1'b1;
          end else if (stat_i.count_nz) begin
            cmd_o.load = 1'b1;
            state_d    = rgbb_pkg::ST_MUL;
          end
        end
      end
      rgbb_pkg::ST_MUL: begin
        cmd_o.mult = 1'b1;
        state_d    = rgbb_pkg::ST_ADD;
      end
      rgbb_pkg::ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = rgbb_pkg::ST_EMIT;
      end
      rgbb_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.span_last) begin
            state_d = rgbb_pkg::ST_IDLE;
          end
        end
      end
    endcase
  end

endmodule

@@ hw/rtl/rgbb_dp.sv @@
// Datapath of the glyph blitter: configuration, pen state, blend and span register.
// Depends on rgbb_pkg; driven by commands from rgbb_ctrl.
module rgbb_dp #(
  parameter int COORD_BITS = rgbb_pkg::COORD_BITS_DEF,
  parameter int DIM_BITS   = rgbb_pkg::DIM_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rgbb_pkg::ctrl_cmd_t                   cmd_i,
  output rgbb_pkg::ctrl_stat_t                  stat_o,
  input  logic                                  cfg_we_i,
  input  logic [rgbb_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [rgbb_pkg::COLOR_BITS-1:0]       cfg_data_i,
  input  logic                                  req_type_i,
  input  logic [COORD_BITS-1:0]                 origin_x_i,
  input  logic [COORD_BITS-1:0]                 origin_y_i,
  input  logic [DIM_BITS-1:0]                   glyph_width_i,
  input  logic [rgbb_pkg::CHAN_BITS-1:0]        run_value_i,
  input  logic [rgbb_pkg::CNT_BITS-1:0]         run_count_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [COORD_BITS:0]                   span_x_o,
  output logic [COORD_BITS:0]                   span_y_o,
  output logic [rgbb_pkg::CNT_BITS-1:0]         span_length_o,
  output logic [rgbb_pkg::COLOR_BITS-1:0]       span_color_o,
  output logic                                  paint_o,
  output logic [rgbb_pkg::LAYER_BITS-1:0]       span_layer_o,
  output logic                                  last_of_run_o,
  output logic                                  glyph_done_o,
  output logic                                  overrun_o
);

  localparam int CB = rgbb_pkg::CHAN_BITS;
  localparam int PB = 2 * rgbb_pkg::CHAN_BITS;
  localparam int NB = rgbb_pkg::CNT_BITS;

  // Configuration registers.
  logic [rgbb_pkg::COLOR_BITS-1:0]  font_q, bg_q;
  logic [rgbb_pkg::HEIGHT_BITS-1:0] height_q;
  logic [rgbb_pkg::LAYER_BITS-1:0]  layer_q;

  // Pen and glyph state.
  logic [DIM_BITS-1:0]   col_q, row_q, width_q;
  logic [COORD_BITS-1:0] base_x_q, base_y_q;
  logic                  active_q;

  // Run being worked on.
  logic [CB-1:0] v_q;
  logic [NB-1:0] rem_q;
  logic [PB-1:0] prod_f_q [rgbb_pkg::NUM_CHAN];
  logic [PB-1:0] prod_b_q [rgbb_pkg::NUM_CHAN];
  logic [rgbb_pkg::COLOR_BITS-1:0] color_q;
  logic                            paint_q;

  logic out_valid_q;

  // Span arithmetic.
  logic [DIM_BITS-1:0] width_in, room, len_dim, height_eff;
  logic [NB-1:0]       len, rem_next;
  logic [DIM_BITS:0]   col_sum, row_inc;
  logic                row_end, span_done, span_last;
  logic [CB-1:0]       chan_sum [rgbb_pkg::NUM_CHAN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_q   <= rgbb_pkg::FONT_COLOR_RST;
      bg_q     <= rgbb_pkg::BG_COLOR_RST;
      height_q <= rgbb_pkg::GLYPH_HEIGHT_RST;
      layer_q  <= rgbb_pkg::LAYER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgbb_pkg::CFG_FONT_COLOR:   font_q   <= cfg_data_i;
        rgbb_pkg::CFG_BG_COLOR:     bg_q     <= cfg_data_i;
        rgbb_pkg::CFG_GLYPH_HEIGHT: height_q <= cfg_data_i[rgbb_pkg::HEIGHT_BITS-1:0];
        rgbb_pkg::CFG_LAYER:        layer_q  <= cfg_data_i[rgbb_pkg::LAYER_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    width_in = (glyph_width_i < DIM_BITS'(rgbb_pkg::MIN_WIDTH))
             ? DIM_BITS'(rgbb_pkg::MIN_WIDTH) : glyph_width_i;
    height_eff = (height_q[DIM_BITS-1:0] == '0) ? DIM_BITS'(1) : height_q[DIM_BITS-1:0];
    room      = width_q - col_q;
    len       = (rem_q < NB'(room)) ? rem_q : NB'(room);
    len_dim   = len[DIM_BITS-1:0];
    rem_next  = rem_q - len;
    col_sum   = (DIM_BITS+1)'(col_q) + (DIM_BITS+1)'(len_dim);
    row_inc   = (DIM_BITS+1)'(row_q) + (DIM_BITS+1)'(1);
    row_end   = col_sum >= (DIM_BITS+1)'(width_q);
    span_done = row_end && (row_inc >= (DIM_BITS+1)'(height_eff));
    // A run with no glyph open yields a single flag span.
    span_last = !active_q || (rem_next == '0) || span_done;
    for (int c = 0; c < rgbb_pkg::NUM_CHAN; c++) begin
      chan_sum[c] = 8'((prod_f_q[c] + prod_b_q[c]) >> CB);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      base_x_q <= '0;
      base_y_q <= '0;
      width_q  <= DIM_BITS'(rgbb_pkg::MIN_WIDTH);
      active_q <= 1'b0;
    end else if (cmd_i.start) begin
      col_q    <= '0;
      row_q    <= '0;
      base_x_q <= origin_x_i;
      base_y_q <= origin_y_i;
      width_q  <= width_in;
      active_q <= 1'b1;
    end else if (cmd_i.emit && active_q) begin
      if (row_end) begin
        col_q <= '0;
        if (span_done) begin
          row_q    <= '0;
          active_q <= 1'b0;
        end else begin
          row_q <= row_inc[DIM_BITS-1:0];
        end
      end else begin
        col_q <= col_sum[DIM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q   <= run_value_i;
      rem_q <= run_count_i;
    end else if (cmd_i.emit) begin
      rem_q <= rem_next;
    end
    if (cmd_i.mult) begin
      for (int c = 0; c < rgbb_pkg::NUM_CHAN; c++) begin
        prod_f_q[c] <= PB'(font_q[c*CB +: CB]) * PB'(v_q);
        prod_b_q[c] <= PB'(bg_q[c*CB +: CB]) * PB'(rgbb_pkg::COV_MAX - v_q);
      end
    end
    if (cmd_i.add) begin
      if (v_q != '0) begin
        color_q <= {rgbb_pkg::ALPHA_OPAQUE, chan_sum[2], chan_sum[1], chan_sum[0]};
        paint_q <= 1'b1;
      end else begin
        color_q <= bg_q;
        paint_q <= bg_q[rgbb_pkg::COLOR_BITS-1 -: CB] != rgbb_pkg::ALPHA_CLEAR;
      end
    end
  end

  // Output register: loads a span, holds it until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      span_layer_o  <= layer_q;
      last_of_run_o <= span_last;
      if (active_q) begin
        span_x_o      <= (COORD_BITS+1)'(base_x_q) + (COORD_BITS+1)'(col_q);
        span_y_o      <= (COORD_BITS+1)'(base_y_q) + (COORD_BITS+1)'(row_q);
        span_length_o <= len;
        span_color_o  <= color_q;
        paint_o       <= paint_q;
        glyph_done_o  <= span_done;
        overrun_o     <= span_done && (rem_next != '0);
      end else begin
        span_x_o      <= '0;
        span_y_o      <= '0;
        span_length_o <= '0;
        span_color_o  <= '0;
        paint_o       <= 1'b0;
        glyph_done_o  <= 1'b0;
        overrun_o     <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o.req_run   = req_type_i == rgbb_pkg::REQ_RUN;
    stat_o.count_nz  = run_count_i != '0;
    stat_o.out_free  = !out_valid_q || out_ready_i;
    stat_o.span_last = span_last;
  end

endmodule

@@ hw/rtl/rle_glyph_blend_blitter.sv @@
// Run-length glyph blitter. A start transaction opens a glyph: it sets the screen
// origin and the glyph width (raised to 8 when narrower) and puts the pen at the
// top-left pixel. Each run transaction (coverage value, pixel count) is painted in
// row-major order from the pen and produces one span transaction for every glyph
// row it touches. A nonzero coverage gives an opaque color whose RGB channels are
// (font*v + bg*(255-v)) >> 8; a zero coverage gives the raw background color,
// painted only when its alpha byte is nonzero. The glyph closes after glyph_height
// rows (0 acts as 1); the span that closes it carries glyph_done, and pixels of
// the run beyond it are dropped with overrun set. A run with no open glyph yields
// one flag span with overrun and last_of_run set, the layer as configured and all
// else zero. Zero-count runs produce nothing. A run passes through the blend
// (multiply, then sum) and then the span generator, which issues one span per cycle
// into a single output register while that register is free or being taken. Input
// is accepted only between runs, while the last span of a run may still wait in
// the output register. Configuration writes must be issued only while the block
// is idle.
module rle_glyph_blend_blitter #(
  parameter int COORD_BITS = rgbb_pkg::COORD_BITS_DEF,
  parameter int DIM_BITS   = rgbb_pkg::DIM_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rgbb_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [rgbb_pkg::COLOR_BITS-1:0]   cfg_data_i,
  rgbb_in_if.sink                           in_i,
  rgbb_out_if.source                        out_o
);

  rgbb_pkg::ctrl_cmd_t  cmd;
  rgbb_pkg::ctrl_stat_t stat;

  // The controller owns the sequencing; it sees the datapath only through
  // the command and status structs.
  rgbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds configuration, pen state, the blend products and the
  // output span register.
  rgbb_dp #(
    .COORD_BITS (COORD_BITS),
    .DIM_BITS   (DIM_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (in_i.req_type),
    .origin_x_i    (in_i.origin_x),
    .origin_y_i    (in_i.origin_y),
    .glyph_width_i (in_i.glyph_width),
    .run_value_i   (in_i.run_value),
    .run_count_i   (in_i.run_count),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .span_x_o      (out_o.span_x),
    .span_y_o      (out_o.span_y),
    .span_length_o (out_o.span_length),
    .span_color_o  (out_o.span_color),
    .paint_o       (out_o.paint),
    .span_layer_o  (out_o.span_layer),
    .last_of_run_o (out_o.last_of_run),
    .glyph_done_o  (out_o.glyph_done),
    .overrun_o     (out_o.overrun)
  );

endmodule

@@ hw/rtl/rgbb_checker.sv @@
// Port-level checker of the glyph blitter and its bind to the top level.
// Depends on rgbb_pkg and on the assertion macros header.
`include "rle_glyph_blend_blitter_macros.svh"

module rgbb_checker #(
  parameter int COORD_BITS = rgbb_pkg::COORD_BITS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [COORD_BITS:0]             span_x_i,
  input logic [rgbb_pkg::CNT_BITS-1:0]   span_length_i,
  input logic [rgbb_pkg::COLOR_BITS-1:0] span_color_i,
  input logic                            paint_i,
  input logic                            last_of_run_i,
  input logic                            glyph_done_i,
  input logic                            overrun_i
);

  // A span that is not taken stays put.
  `RGBB_ASSERT_NXT(a_span_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(span_x_i) && $stable(span_length_i) && $stable(span_color_i), "span changed while stalled")

  // Closing the glyph or dropping pixels always ends the run.
  `RGBB_ASSERT_IMP(a_end_is_last, out_valid_i && (glyph_done_i || overrun_i), last_of_run_i, "glyph end or overrun without last_of_run")

  // An empty span is only the flag span of a run with no open glyph.
  `RGBB_ASSERT_IMP(a_empty_is_flag, out_valid_i && (span_length_i == '0), overrun_i && last_of_run_i && !paint_i && !glyph_done_i && (span_color_i == '0), "malformed empty span")

  // Painting follows the alpha byte of the span color.
  `RGBB_ASSERT_IMP(a_paint_alpha, out_valid_i, paint_i == (span_color_i[rgbb_pkg::COLOR_BITS-1 -: rgbb_pkg::CHAN_BITS] != rgbb_pkg::ALPHA_CLEAR), "paint disagrees with alpha")

endmodule

bind rle_glyph_blend_blitter rgbb_checker #(
  .COORD_BITS (COORD_BITS)
) u_rgbb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .span_x_i      (out_o.span_x),
  .span_length_i (out_o.span_length),
  .span_color_i  (out_o.span_color),
  .paint_i       (out_o.paint),
  .last_of_run_i (out_o.last_of_run),
  .glyph_done_i  (out_o.glyph_done),
  .overrun_i     (out_o.overrun)
);

@@ sim/tb_rle_glyph_blend_blitter.sv @@
// Self-checking testbench of the run-length glyph blitter: directed and random glyph traffic.
// Depends on rgbb_pkg, the rgbb_in_if/rgbb_out_if interfaces and rle_glyph_blend_blitter.
`timescale 1ns / 100ps

module tb_rle_glyph_blend_blitter;

  localparam int CB            = rgbb_pkg::COORD_BITS_DEF;
  localparam int DB            = rgbb_pkg::DIM_BITS_DEF;
  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int MAX_SPANS     = 33;
  // A run yields at most MAX_SPANS spans, and its last span is emitted as the block
  // returns to idle, so SETTLE_CYCLES of margin after the drain are enough.
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 40;
  localparam int CYCLE_LIMIT   = 400000;

  // One input transaction, split into its fields.
  typedef struct packed {
    logic                           req_type;
    logic [CB-1:0]                  origin_x;
    logic [CB-1:0]                  origin_y;
    logic [DB-1:0]                  glyph_width;
    logic [rgbb_pkg::CHAN_BITS-1:0] run_value;
    logic [rgbb_pkg::CNT_BITS-1:0]  run_count;
  } glyph_req_t;

  localparam int REQ_BITS = $bits(glyph_req_t);

  // One span transaction as the block should produce it.
  typedef struct packed {
    logic [CB:0]                     x;
    logic [CB:0]                     y;
    logic [rgbb_pkg::CNT_BITS-1:0]   len;
    logic [rgbb_pkg::COLOR_BITS-1:0] color;
    logic                            paint;
    logic [rgbb_pkg::LAYER_BITS-1:0] layer;
    logic                            last;
    logic                            done;
    logic                            over;
  } span_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                              cfg_we_i;
  logic [rgbb_pkg::CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [rgbb_pkg::COLOR_BITS-1:0]   cfg_data_i;

  rgbb_in_if  #(.COORD_BITS(CB), .DIM_BITS(DB)) glyph_in ();
  rgbb_out_if #(.COORD_BITS(CB))                span_out ();

  rle_glyph_blend_blitter #(
    .COORD_BITS(CB),
    .DIM_BITS  (DB)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (glyph_in),
    .out_o     (span_out)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Spans that the block still owes, oldest first.
  span_t pending_spans[$];
  int    error_count = 0;
  int    cycle_count = 0;

  // Idling controls. The percentages give the chance per cycle that the sender
  // idles or the receiver stalls; hold_cycles forces a long receiver stall.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;

  // Our copy of the configuration registers.
  logic [rgbb_pkg::COLOR_BITS-1:0]  reg_font   = rgbb_pkg::FONT_COLOR_RST;
  logic [rgbb_pkg::COLOR_BITS-1:0]  reg_bg     = rgbb_pkg::BG_COLOR_RST;
  logic [rgbb_pkg::HEIGHT_BITS-1:0] reg_height = rgbb_pkg::GLYPH_HEIGHT_RST;
  logic [rgbb_pkg::LAYER_BITS-1:0]  reg_layer  = rgbb_pkg::LAYER_RST;

  // Our copy of the pen: glyph origin, width, current column and row.
  int unsigned org_x      = 0;
  int unsigned org_y      = 0;
  int unsigned glyph_w    = rgbb_pkg::MIN_WIDTH;
  int unsigned pen_col    = 0;
  int unsigned pen_row    = 0;
  logic        glyph_open = 1'b0;

  task automatic log_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  function automatic logic [rgbb_pkg::CHAN_BITS-1:0] blend_chan(
      logic [rgbb_pkg::CHAN_BITS-1:0] f,
      logic [rgbb_pkg::CHAN_BITS-1:0] b,
      logic [rgbb_pkg::CHAN_BITS-1:0] v);
    int mix;
    mix = int'(f) * int'(v) + int'(b) * (int'(rgbb_pkg::COV_MAX) - int'(v));
    return mix[15:8];
  endfunction

  // Works out the spans that one accepted transaction causes and queues them.
  task automatic predict_spans(glyph_req_t r);
    span_t                           s;
    int unsigned                     left;
    int unsigned                     room;
    int unsigned                     len;
    int unsigned                     height;
    int unsigned                     nspan;
    logic [rgbb_pkg::COLOR_BITS-1:0] color;
    logic                            paint;
    logic                            closed;
    if (r.req_type == rgbb_pkg::REQ_START) begin
      // The run fields of a start are ignored; narrow glyphs are widened to 8.
      org_x      = 32'(r.origin_x);
      org_y      = 32'(r.origin_y);
      glyph_w    = (32'(r.glyph_width) < 32'(rgbb_pkg::MIN_WIDTH))
                 ? 32'(rgbb_pkg::MIN_WIDTH) : 32'(r.glyph_width);
      pen_col    = 0;
      pen_row    = 0;
      glyph_open = 1'b1;
      return;
    end
    left = 32'(r.run_count);
    if (left == 0) return;
    s       = '0;
    s.layer = reg_layer;
    if (!glyph_open) begin
      // A run with no open glyph gets a single flag span.
      s.last = 1'b1;
      s.over = 1'b1;
      pending_spans.push_back(s);
      return;
    end
    if (r.run_value != '0) begin
      color = {rgbb_pkg::ALPHA_OPAQUE,
               blend_chan(reg_font[23:16], reg_bg[23:16], r.run_value),
               blend_chan(reg_font[15:8],  reg_bg[15:8],  r.run_value),
               blend_chan(reg_font[7:0],   reg_bg[7:0],   r.run_value)};
      paint = 1'b1;
    end else begin
      color = reg_bg;
      paint = (reg_bg[31:24] != rgbb_pkg::ALPHA_CLEAR);
    end
    height = (reg_height == '0) ? 32'd1 : 32'(reg_height);
    nspan  = 0;
    while (left > 0 && glyph_open && nspan < MAX_SPANS) begin
      room    = glyph_w - pen_col;
      len     = (left < room) ? left : room;
      s.x     = (CB+1)'(org_x + pen_col);
      s.y     = (CB+1)'(org_y + pen_row);
      left    = left - len;
      pen_col = pen_col + len;
      closed  = 1'b0;
      if (pen_col >= glyph_w) begin
        pen_col = 0;
        // With the height lowered mid-glyph, any later row end closes the glyph.
        if (pen_row + 1 >= height) begin
          closed     = 1'b1;
          glyph_open = 1'b0;
          pen_row    = 0;
        end else begin
          pen_row = (pen_row + 1) & 32'hFF;
        end
      end
      s.len   = rgbb_pkg::CNT_BITS'(len);
      s.color = color;
      s.paint = paint;
      s.done  = closed;
      s.over  = closed && (left > 0);
      s.last  = (left == 0) || closed;
      pending_spans.push_back(s);
      nspan++;
    end
  endtask

  // Offers one transaction, idling first as the sender setting asks, and
  // predicts its spans once the block has taken it.
  task automatic send_item(glyph_req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      glyph_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    glyph_in.valid       <= 1'b1;
    glyph_in.req_type    <= r.req_type;
    glyph_in.origin_x    <= r.origin_x;
    glyph_in.origin_y    <= r.origin_y;
    glyph_in.glyph_width <= r.glyph_width;
    glyph_in.run_value   <= r.run_value;
    glyph_in.run_count   <= r.run_count;
    @(posedge clk_i);
    while (!glyph_in.ready) @(posedge clk_i);
    predict_spans(r);
  endtask

  // The fields that a start or a run does not use carry random values.
  task automatic send_start(int unsigned x, int unsigned y, int unsigned w);
    glyph_req_t r;
    r             = glyph_req_t'(REQ_BITS'({$urandom, $urandom}));
    r.req_type    = rgbb_pkg::REQ_START;
    r.origin_x    = CB'(x);
    r.origin_y    = CB'(y);
    r.glyph_width = DB'(w);
    send_item(r);
  endtask

  task automatic send_run(int unsigned v, int unsigned c);
    glyph_req_t r;
    r           = glyph_req_t'(REQ_BITS'({$urandom, $urandom}));
    r.req_type  = rgbb_pkg::REQ_RUN;
    r.run_value = rgbb_pkg::CHAN_BITS'(v);
    r.run_count = rgbb_pkg::CNT_BITS'(c);
    send_item(r);
  endtask

  // Lowers valid, waits for every owed span and lets the block settle.
  task automatic drain_spans();
    @(negedge clk_i);
    glyph_in.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register writes happen only with the block at rest.
  task automatic write_reg(logic [rgbb_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [rgbb_pkg::COLOR_BITS-1:0] data);
    drain_spans();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      rgbb_pkg::CFG_FONT_COLOR:   reg_font   = data;
      rgbb_pkg::CFG_BG_COLOR:     reg_bg     = data;
      rgbb_pkg::CFG_GLYPH_HEIGHT: reg_height = data[rgbb_pkg::HEIGHT_BITS-1:0];
      default:                    reg_layer  = data[rgbb_pkg::LAYER_BITS-1:0];
    endcase
  endtask

  function automatic logic [rgbb_pkg::COLOR_BITS-1:0] pick_color();
    case ($urandom_range(2))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed glyphs: a start, then runs that walk the glyph to its end.
  // About one item in ten is noise, and a few restart a glyph in the middle.
  task automatic run_random_traffic(int n_items);
    glyph_req_t  r;
    int unsigned pick;
    int unsigned span_max;
    for (int i = 0; i < n_items; i++) begin
      r    = glyph_req_t'(REQ_BITS'({$urandom, $urandom}));
      pick = $urandom_range(99);
      if (pick < 10) begin
        r.req_type = 1'($urandom_range(1));
      end else if (!glyph_open || pick < 14) begin
        r.req_type = rgbb_pkg::REQ_START;
        case ($urandom_range(9))
          0:       r.glyph_width = DB'($urandom_range(rgbb_pkg::MIN_WIDTH - 1));
          1:       r.glyph_width = '1;
          2:       r.glyph_width = DB'($urandom);
          default: r.glyph_width = DB'($urandom_range(24, rgbb_pkg::MIN_WIDTH));
        endcase
      end else begin
        r.req_type = rgbb_pkg::REQ_RUN;
        case ($urandom_range(7))
          0:       r.run_value = '0;
          1:       r.run_value = rgbb_pkg::COV_MAX;
          default: r.run_value = rgbb_pkg::CHAN_BITS'($urandom);
        endcase
        span_max = (2 * glyph_w > 255) ? 255 : 2 * glyph_w;
        case ($urandom_range(19))
          0:       r.run_count = '0;
          1:       r.run_count = '1;
          default: r.run_count = rgbb_pkg::CNT_BITS'($urandom_range(span_max, 1));
        endcase
      end
      send_item(r);
    end
  endtask

  // One phase of random traffic with its own idling and a fresh configuration.
  task automatic random_phase(int idle_pct, int stall, int n_items);
    logic [rgbb_pkg::HEIGHT_BITS-1:0] height;
    case ($urandom_range(9))
      0:       height = '0;
      1:       height = '1;
      2:       height = 8'd1;
      default: height = rgbb_pkg::HEIGHT_BITS'($urandom_range(6, 2));
    endcase
    write_reg(rgbb_pkg::CFG_FONT_COLOR, pick_color());
    write_reg(rgbb_pkg::CFG_BG_COLOR, pick_color());
    write_reg(rgbb_pkg::CFG_GLYPH_HEIGHT, 32'(height));
    write_reg(rgbb_pkg::CFG_LAYER, $urandom_range(15));
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    run_random_traffic(n_items);
    drain_spans();
  endtask

  // Runs with no glyph open: one flag span each, and nothing for zero counts.
  task automatic test_no_glyph_runs();
    send_run(77, 5);
    send_run(0, 0);
    send_run(32'(rgbb_pkg::COV_MAX), 255);
    drain_spans();
  endtask

  // Reset configuration, a glyph narrower than 8 at the far screen corner, a
  // transparent background run, a run past the glyph end and a run after it.
  task automatic test_narrow_glyph_overrun();
    send_start('1, '1, 3);
    send_run(32'(rgbb_pkg::COV_MAX), 1);
    send_run(0, 7);
    send_run(1, 255);
    send_run(200, 9);
    send_run(0, 0);
    drain_spans();
  endtask

  // Extremes of every register: zero height acts as one row, widest glyph, top layer.
  task automatic test_register_extremes();
    write_reg(rgbb_pkg::CFG_FONT_COLOR, '0);
    write_reg(rgbb_pkg::CFG_BG_COLOR, '1);
    write_reg(rgbb_pkg::CFG_GLYPH_HEIGHT, '0);
    write_reg(rgbb_pkg::CFG_LAYER, 32'd15);
    send_start(0, 0, 255);
    send_run(128, 200);
    send_run(0, 55);
    send_run(9, 3);
    // A background with clear alpha still sends its raw color, unpainted.
    write_reg(rgbb_pkg::CFG_BG_COLOR, 32'h00A5_C3E1);
    write_reg(rgbb_pkg::CFG_FONT_COLOR, 32'h005A_3C1E);
    write_reg(rgbb_pkg::CFG_GLYPH_HEIGHT, 32'd255);
    send_start(32'h800, 32'h7FF, 8);
    send_run(0, 12);
    send_run(32'(rgbb_pkg::COV_MAX), 30);
    drain_spans();
  endtask

  // The height drops below the current row while a glyph is open.
  task automatic test_height_lowered();
    write_reg(rgbb_pkg::CFG_GLYPH_HEIGHT, 32'd4);
    write_reg(rgbb_pkg::CFG_LAYER, 32'd0);
    write_reg(rgbb_pkg::CFG_FONT_COLOR, '1);
    send_start(100, 200, 8);
    send_run(60, 24);
    write_reg(rgbb_pkg::CFG_GLYPH_HEIGHT, 32'd2);
    send_run(61, 12);
    drain_spans();
  endtask

  task automatic test_random_traffic();
    random_phase(0, 0, 60);
    random_phase(81, 0, 60);
    random_phase(0, 81, 60);
    random_phase(26, 26, 60);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // runs, so the output register fills and the input stalls.
  task automatic test_backpressure();
    write_reg(rgbb_pkg::CFG_GLYPH_HEIGHT, 32'd200);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 300;
    send_start($urandom, $urandom, 16);
    for (int i = 0; i < 20; i++) begin
      send_run($urandom, $urandom_range(40, 1));
    end
    drain_spans();
  endtask

  // Receiver: ready changes at the falling edge, either held low for a forced
  // stretch or stalling at random with the chance that stall_pct gives.
  initial begin
    span_out.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        span_out.ready <= 1'b0;
        hold_cycles--;
      end else begin
        span_out.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Every span transaction is checked against the oldest owed span.
  always @(posedge clk_i) begin : span_checker
    span_t want;
    if (rst_ni && span_out.valid && span_out.ready) begin
      if (pending_spans.size() == 0) begin
        log_mismatch($sformatf("unexpected span x=0x%0h y=0x%0h len=%0d",
                               span_out.span_x, span_out.span_y, span_out.span_length));
      end else begin
        want = pending_spans.pop_front();
        check_field("span_x", 32'(span_out.span_x), 32'(want.x));
        check_field("span_y", 32'(span_out.span_y), 32'(want.y));
        check_field("span_length", 32'(span_out.span_length), 32'(want.len));
        check_field("span_color", span_out.span_color, want.color);
        check_field("paint", 32'(span_out.paint), 32'(want.paint));
        check_field("span_layer", 32'(span_out.span_layer), 32'(want.layer));
        check_field("last_of_run", 32'(span_out.last_of_run), 32'(want.last));
        check_field("glyph_done", 32'(span_out.glyph_done), 32'(want.done));
        check_field("overrun", 32'(span_out.overrun), 32'(want.over));
      end
    end
  end

  // Watchdog: the run is cut off if it goes on far longer than it should.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("ERROR: cycle limit reached with %0d spans owed", pending_spans.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    glyph_in.valid       <= 1'b0;
    glyph_in.req_type    <= rgbb_pkg::REQ_START;
    glyph_in.origin_x    <= '0;
    glyph_in.origin_y    <= '0;
    glyph_in.glyph_width <= '0;
    glyph_in.run_value   <= '0;
    glyph_in.run_count   <= '0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= rgbb_pkg::CFG_FONT_COLOR;
    cfg_data_i           <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_no_glyph_runs();
    test_narrow_glyph_overrun();
    test_register_extremes();
    test_height_lowered();
    test_random_traffic();
    test_backpressure();

    drain_spans();
    repeat (END_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
